FILE: hdl/sqwns_pkg.sv
// Types and constants shared by the square-wave note sequencer files.
package sqwns_pkg;

  // Input word kinds carried on s_tuser.
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_LOAD     = 3'd1,
    ACT_START    = 3'd2,
    ACT_CANCEL   = 3'd3,
    ACT_THROTTLE = 3'd4,
    ACT_RESET    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PLAYING  = 2'd1,
    MODE_FINISHED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOTE,
    ST_DECIDE,
    ST_DIV,
    ST_TOGGLE,
    ST_EMIT
  } state_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_AMPLITUDE  = 2'd0;
  localparam logic [1:0] CFG_GAP_US     = 2'd1;
  localparam logic [1:0] CFG_SKIP       = 2'd2;
  localparam logic [1:0] CFG_NOTE_COUNT = 2'd3;

  localparam logic [16:0] AMPLITUDE_RST  = 17'd5000;
  localparam logic [19:0] GAP_US_RST     = 20'd40000;
  localparam logic [9:0]  SKIP_RST       = 10'd100;
  localparam logic [6:0]  NOTE_COUNT_RST = 7'd46;

  // Half period in us is HALF_PERIOD_NUM / freq.
  localparam logic [18:0] HALF_PERIOD_NUM = 19'd500000;
  localparam int          DIV_STEPS       = 19;
  localparam logic [9:0]  US_PER_MS       = 10'd1000;

  // Table entry layout, lowest bits first: freq, duration, voice.
  localparam int ENTRY_W = 34;

endpackage

FILE: hdl/sqwns_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sqwns_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/square_wave_note_sequencer.sv
// Top level of the square-wave note sequencer.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser action, tdata note/tick/throttle fields
// m_*      out  m_tvalid/m_tready  tuser frame_valid, tdata command, tlast last
// cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// One input word at a time. A tick while playing that reaches the toggle check
// passes a note table read, a multiply, a decision, a 19-step restoring
// divider for the half period and the toggle before its first result word.
// A tick that ends the note or falls in a rest or gap skips the divider and the
// toggle; all other words go straight to output. Then 1 to 3 result words
// follow, one per cycle while m_tready is high. s_tready is low until the last
// result word of the current input is taken. Reset (rst, synchronous) sets idle
// mode and default registers; the note table holds no reset value.
module square_wave_note_sequencer
  import sqwns_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[2:0]
  input  logic [2:0]  s_tuser,
  // elapsed_us[16:0], note_slot[22:17], note_freq_hz[38:23],
  // note_duration_ms[54:39], note_voice[56:55], throttle_calibrated[57],
  // throttle_permille[67:58], zero fill[71:68]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_valid[0]
  output logic        m_tuser,
  output logic        m_tlast,
  // motor_select[0], command_value[18:1], is_playing[19], is_finished[20],
  // zero fill[23:21]
  output logic [23:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (PW > 7) ? PW : 7;

  // Configuration.
  logic [16:0] amplitude;
  logic [19:0] gap_us;
  logic [9:0]  skip_permille;
  logic [6:0]  note_count;

  // Control state.
  state_t        state, state_next;
  mode_t         mode;
  logic          cancel_pending;
  logic [PW-1:0] position;
  logic [31:0]   note_timer;
  logic [31:0]   toggle_timer;
  logic          sign_neg;
  logic          silenced;
  logic [17:0]   mcmd [2];
  logic [1:0]    res_cnt;
  logic [1:0]    out_idx;
  logic [4:0]    div_cnt;

  // Working registers for the current tick.
  logic [15:0] note_freq;
  logic        note_sel;
  logic [25:0] dur_us;
  logic [15:0] div_rem;
  logic [18:0] div_quo;
  logic        res_sel [3];
  logic [17:0] res_cmd [3];

  // Input field unpack.
  action_t     action;
  logic [16:0] in_elapsed;
  logic [5:0]  in_slot;
  logic [15:0] in_freq;
  logic [15:0] in_dur;
  logic [1:0]  in_voice;
  logic        in_calib;
  logic [9:0]  in_permille;

  assign action      = action_t'(s_tuser);
  assign in_elapsed  = s_tdata[16:0];
  assign in_slot     = s_tdata[22:17];
  assign in_freq     = s_tdata[38:23];
  assign in_dur      = s_tdata[54:39];
  assign in_voice    = s_tdata[56:55];
  assign in_calib    = s_tdata[57];
  assign in_permille = s_tdata[67:58];

  logic s_acc, m_acc, out_last;
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;
  assign out_last = (res_cnt == 2'd0) || (out_idx == res_cnt - 2'd1);

  // Note table.
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                slot_ok;

  assign slot_ok = 32'(in_slot) < TABLE_DEPTH;
  assign ram_we  = s_acc && (action == ACT_LOAD) && slot_ok;

  sqwns_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_slot)),
    .wdata ({in_voice, in_dur, in_freq}),
    .re    (s_acc),
    .raddr (position[AW-1:0]),
    .rdata (ram_rdata)
  );

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [16:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Song length, clamped to 1..TABLE_DEPTH.
  logic [CW-1:0] song_len, pos_inc;
  always_comb begin
    if (note_count == 7'd0) begin
      song_len = CW'(1);
    end else if (32'(note_count) > TABLE_DEPTH) begin
      song_len = CW'(TABLE_DEPTH);
    end else begin
      song_len = CW'(note_count);
    end
  end
  assign pos_inc = CW'(position) + CW'(1);

  // Tick decisions.
  logic        note_end, in_gap, drop, song_done, toggle_now, sign_new;
  logic [1:0]  sil_base;
  logic [17:0] amp_ext, toggle_cmd;

  assign note_end   = note_timer >= 32'(dur_us);
  assign in_gap     = (note_freq == 16'd0) ||
                      ((dur_us > 26'(gap_us)) && (note_timer >= 32'(dur_us - 26'(gap_us))));
  assign drop       = mcmd[note_sel] != 18'd0;
  assign song_done  = pos_inc >= song_len;
  assign sil_base   = {1'b0, drop};
  assign toggle_now = toggle_timer >= 32'(div_quo);
  assign sign_new   = ~sign_neg;
  assign amp_ext    = {1'b0, amplitude};
  assign toggle_cmd = sign_new ? (18'd0 - amp_ext) : amp_ext;

  // Divider step.
  logic [16:0] trial, trial_sub;
  logic        trial_ge;
  assign trial     = {div_rem, div_quo[18]};
  assign trial_sub = trial - {1'b0, note_freq};
  assign trial_ge  = trial >= {1'b0, note_freq};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (action == ACT_TICK && mode == MODE_PLAYING && !cancel_pending) begin
            state_next = ST_NOTE;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_NOTE:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = (note_end || in_gap) ? ST_EMIT : ST_DIV;
      ST_DIV: begin
        if (div_cnt == 5'(DIV_STEPS - 1)) begin
          state_next = ST_TOGGLE;
        end
      end
      ST_TOGGLE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (m_acc && out_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    m_tvalid  = (state == ST_EMIT);
    m_tlast   = out_last;
    m_tuser   = (res_cnt != 2'd0);
    m_tdata   = '0;
    if (res_cnt != 2'd0) begin
      m_tdata[0]    = res_sel[out_idx];
      m_tdata[18:1] = res_cmd[out_idx];
    end
    m_tdata[19] = (mode == MODE_PLAYING);
    m_tdata[20] = (mode == MODE_FINISHED);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude     <= AMPLITUDE_RST;
      gap_us        <= GAP_US_RST;
      skip_permille <= SKIP_RST;
      note_count    <= NOTE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_AMPLITUDE:  amplitude     <= cfg_data[16:0];
        CFG_GAP_US:     gap_us        <= cfg_data;
        CFG_SKIP:       skip_permille <= cfg_data[9:0];
        CFG_NOTE_COUNT: note_count    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= MODE_IDLE;
      cancel_pending <= 1'b0;
      position       <= '0;
      note_timer     <= '0;
      toggle_timer   <= '0;
      sign_neg       <= 1'b0;
      silenced       <= 1'b0;
      mcmd[0]        <= '0;
      mcmd[1]        <= '0;
      res_cnt        <= '0;
      out_idx        <= '0;
      div_cnt        <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (action)
              ACT_TICK: begin
                if (mode != MODE_PLAYING) begin
                  cancel_pending <= 1'b0;
                end else if (cancel_pending) begin
                  mcmd[0]        <= '0;
                  mcmd[1]        <= '0;
                  res_sel[0]     <= 1'b0;
                  res_cmd[0]     <= '0;
                  res_sel[1]     <= 1'b1;
                  res_cmd[1]     <= '0;
                  res_cnt        <= 2'd2;
                  cancel_pending <= 1'b0;
                  mode           <= MODE_IDLE;
                end else begin
                  note_timer   <= sat_add(note_timer, in_elapsed);
                  toggle_timer <= sat_add(toggle_timer, in_elapsed);
                end
              end
              ACT_START: begin
                position       <= '0;
                sign_neg       <= 1'b0;
                silenced       <= 1'b0;
                cancel_pending <= 1'b0;
                mode           <= MODE_PLAYING;
                note_timer     <= '0;
                toggle_timer   <= '0;
              end
              ACT_CANCEL: begin
                if (mode == MODE_PLAYING) begin
                  cancel_pending <= 1'b1;
                end
              end
              ACT_THROTTLE: begin
                if (mode == MODE_PLAYING && in_calib && in_permille > skip_permille) begin
                  mcmd[0]    <= '0;
                  mcmd[1]    <= '0;
                  res_sel[0] <= 1'b0;
                  res_cmd[0] <= '0;
                  res_sel[1] <= 1'b1;
                  res_cmd[1] <= '0;
                  res_cnt    <= 2'd2;
                  mode       <= MODE_FINISHED;
                end
              end
              ACT_RESET: begin
                if (mode == MODE_FINISHED) begin
                  mode <= MODE_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_NOTE: begin
          note_freq <= ram_rdata[15:0];
          note_sel  <= ram_rdata[32];
          dur_us    <= ram_rdata[31:16] * US_PER_MS;
        end
        ST_DECIDE: begin
          div_rem <= '0;
          div_quo <= HALF_PERIOD_NUM;
          div_cnt <= '0;
          if (note_end) begin
            if (drop) begin
              res_sel[0]     <= note_sel;
              res_cmd[0]     <= '0;
            end
            position <= PW'(pos_inc);
            if (song_done) begin
              // note-end drop first, then both motors silenced
              mcmd[0]              <= '0;
              mcmd[1]              <= '0;
              res_sel[sil_base]         <= 1'b0;
              res_cmd[sil_base]         <= '0;
              res_sel[sil_base + 2'd1]  <= 1'b1;
              res_cmd[sil_base + 2'd1]  <= '0;
              res_cnt              <= drop ? 2'd3 : 2'd2;
              mode                 <= MODE_FINISHED;
            end else begin
              if (drop) begin
                mcmd[note_sel] <= '0;
              end
              res_cnt      <= {1'b0, drop};
              sign_neg     <= 1'b0;
              silenced     <= 1'b0;
              note_timer   <= '0;
              toggle_timer <= '0;
            end
          end else if (in_gap) begin
            if (!silenced && drop) begin
              mcmd[note_sel] <= '0;
              res_sel[0]     <= note_sel;
              res_cmd[0]     <= '0;
              res_cnt        <= 2'd1;
            end
            silenced <= 1'b1;
          end
        end
        ST_DIV: begin
          div_rem <= trial_ge ? trial_sub[15:0] : trial[15:0];
          div_quo <= {div_quo[17:0], trial_ge};
          div_cnt <= div_cnt + 5'd1;
        end
        ST_TOGGLE: begin
          if (toggle_now) begin
            toggle_timer   <= '0;
            sign_neg       <= sign_new;
            mcmd[note_sel] <= toggle_cmd;
            res_sel[0]     <= note_sel;
            res_cmd[0]     <= toggle_cmd;
            res_cnt        <= 2'd1;
          end
        end
        ST_EMIT: begin
          if (m_acc && out_last) begin
            res_cnt <= 2'd0;
            out_idx <= 2'd0;
          end else if (m_acc) begin
            out_idx <= out_idx + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/sqwns_chk.sv
// Port-level checker for the square-wave note sequencer, bound to the top level.
module sqwns_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic        m_tuser,
  input logic        m_tlast,
  input logic [23:0] m_tdata
);

  // A status word never shares its input with command frames.
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("status word without last");

  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[19] && m_tdata[20]))
    else $error("playing and finished both set");

  // Input is held off while results of the previous word are pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while results pending");

  // Status words carry no command.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[18:0] == 19'd0)
    else $error("status word with command bits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result word changed");

endmodule

bind square_wave_note_sequencer sqwns_chk u_sqwns_chk (.*);
